FILE: hw/rtl/ycc565_pkg.sv
// Shared types, constants and helpers for the YCbCr to RGB565 pixel pipeline.
// Used by ycc565_mult, ycc565_conv and the top level; no dependencies.
package ycc565_pkg;

    // Fixed-point color matrix, 2.16 format, carried as signed operands
    localparam logic signed [17:0] K_CR_TO_R = 18'sh166e9;
    localparam logic signed [17:0] K_CB_TO_G = 18'sh0581a;
    localparam logic signed [17:0] K_CR_TO_G = 18'sh0b6d2;
    localparam logic signed [17:0] K_CB_TO_B = 18'sh1c5a2;

    // Product width: 17-bit magnitude coefficient times 8-bit signed chroma
    localparam int PROD_W = 25;
    // Rounded color offset: product with the 16 fraction bits dropped
    localparam int OFF_W  = PROD_W - 16;
    // Luma plus offset, one bit of headroom
    localparam int SUM_W  = OFF_W + 1;

    // Half of one LSB after the shift
    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(32768);

    // Row and frame markers that ride along with each pixel
    typedef struct packed {
        logic frame_end;
        logic row_end;
    } t_side;

    // Centered chroma: offset-128 byte becomes a signed byte by flipping the MSB
    function automatic logic signed [7:0] center_chroma(input logic [7:0] c);
        center_chroma = signed'({~c[7], c[6:0]});
    endfunction

    // Round a 9.16 value to nearest, ties upward (floor after +0.5)
    function automatic logic signed [OFF_W-1:0] round_fix16(
        input logic signed [PROD_W-1:0] v
    );
        logic signed [PROD_W-1:0] s;
        s = v + ROUND_HALF;
        round_fix16 = s[PROD_W-1:16];
    endfunction

    // Add offset to luma and clamp to 0..255
    function automatic logic [7:0] add_clamp(
        input logic [7:0]              y,
        input logic signed [OFF_W-1:0] off
    );
        logic signed [SUM_W-1:0] s;
        s = signed'(SUM_W'({1'b0, y})) + SUM_W'(off);
        if (s[SUM_W-1]) begin
            add_clamp = 8'd0;
        end else if (|s[SUM_W-2:8]) begin
            add_clamp = 8'd255;
        end else begin
            add_clamp = s[7:0];
        end
    endfunction

endpackage

FILE: hw/rtl/ycbcr_to_rgb565_pixel.sv
// Top level of the YCbCr to RGB565 pixel converter.
// Depends on ycc565_pkg, ycc565_mult and ycc565_conv.
//
// Usage:
//   Slave stream (s_axis_*) takes one JPEG pixel per item: Y, Cb, Cr bytes in
//   tdata and the row/frame end markers in tuser. Master stream (m_axis_*)
//   gives one RGB565 word per item with the same markers copied through.
//   Pipeline: four register stages (center, multiply, round, add/clamp/pack);
//   the accepting edge loads the first one and the item then moves through
//   the multiply and round registers into the output register.
//   Throughput: one item per clock unless stalled; every stage holds a valid bit
//   and loads whenever it is empty or its item moves forward, so bubbles collapse.
//   Stall: when m_axis_tready is low the output register holds its item and
//   the pipeline keeps filling its empty stages; s_axis_tready drops only
//   once all four stages hold items. Nothing is dropped or duplicated.
//   Reset (i_rst_n low, synchronous) clears all valid bits; in-flight items
//   are discarded. No configuration and no state beyond the pipeline.
module ycbcr_to_rgb565_pixel (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [7:0] luma, [15:8] chroma_blue, [23:16] chroma_red
    input  logic [1:0]  s_axis_tuser,   // [0] row_end, [1] frame_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] pixel_565
    output logic [1:0]  m_axis_tuser    // [0] row_end_out, [1] frame_end_out
);
    import ycc565_pkg::*;

    // Link between the two halves
    logic                     mid_valid;
    logic                     mid_ready;
    logic [7:0]               mid_luma;
    logic signed [PROD_W-1:0] mid_prod_r;
    logic signed [PROD_W-1:0] mid_prod_g_cb;
    logic signed [PROD_W-1:0] mid_prod_g_cr;
    logic signed [PROD_W-1:0] mid_prod_b;
    t_side                    mid_side;
    t_side                    in_side;
    t_side                    out_side;

    assign in_side.row_end   = s_axis_tuser[0];
    assign in_side.frame_end = s_axis_tuser[1];

    // Centering and multiply stages
    ycc565_mult u_mult (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_luma        (s_axis_tdata[7:0]),
        .i_chroma_blue (s_axis_tdata[15:8]),
        .i_chroma_red  (s_axis_tdata[23:16]),
        .i_side        (in_side),
        .o_valid       (mid_valid),
        .i_ready       (mid_ready),
        .o_luma        (mid_luma),
        .o_prod_r      (mid_prod_r),
        .o_prod_g_cb   (mid_prod_g_cb),
        .o_prod_g_cr   (mid_prod_g_cr),
        .o_prod_b      (mid_prod_b),
        .o_side        (mid_side)
    );

    // Rounding, clamp and pack stages
    ycc565_conv u_conv (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (mid_valid),
        .o_ready     (mid_ready),
        .i_luma      (mid_luma),
        .i_prod_r    (mid_prod_r),
        .i_prod_g_cb (mid_prod_g_cb),
        .i_prod_g_cr (mid_prod_g_cr),
        .i_prod_b    (mid_prod_b),
        .i_side      (mid_side),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_pixel_565 (m_axis_tdata),
        .o_side      (out_side)
    );

    assign m_axis_tuser = {out_side.frame_end, out_side.row_end};

endmodule

FILE: hw/rtl/ycc565_mult.sv
// Front half of the pixel pipeline: chroma centering stage, then the
// coefficient multiply stage. Depends on ycc565_pkg.
module ycc565_mult (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic [7:0]                             i_luma,
    input  logic [7:0]                             i_chroma_blue,
    input  logic [7:0]                             i_chroma_red,
    input  ycc565_pkg::t_side                      i_side,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic [7:0]                             o_luma,
    output logic signed [ycc565_pkg::PROD_W-1:0]   o_prod_r,
    output logic signed [ycc565_pkg::PROD_W-1:0]   o_prod_g_cb,
    output logic signed [ycc565_pkg::PROD_W-1:0]   o_prod_g_cr,
    output logic signed [ycc565_pkg::PROD_W-1:0]   o_prod_b,
    output ycc565_pkg::t_side                      o_side
);
    import ycc565_pkg::*;

    // Stage 1 registers: luma and centered chroma
    logic              r_v1;
    logic [7:0]        r_y1;
    logic signed [7:0] r_cb1;
    logic signed [7:0] r_cr1;
    t_side             r_side1;

    // Stage 2 registers: products
    logic                     r_v2;
    logic [7:0]               r_y2;
    logic signed [PROD_W-1:0] r_pr2;
    logic signed [PROD_W-1:0] r_pgb2;
    logic signed [PROD_W-1:0] r_pgr2;
    logic signed [PROD_W-1:0] r_pb2;
    t_side                    r_side2;

    logic en1;
    logic en2;

    // A stage loads when it is empty or its item moves on this cycle
    assign en2     = !r_v2 || i_ready;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
        end
    end

    // Stage 1: center chroma
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_y1    <= i_luma;
            r_cb1   <= center_chroma(i_chroma_blue);
            r_cr1   <= center_chroma(i_chroma_red);
            r_side1 <= i_side;
        end
    end

    // Stage 2: four coefficient products
    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_y2    <= r_y1;
            r_pr2   <= PROD_W'(K_CR_TO_R) * PROD_W'(r_cr1);
            r_pgb2  <= PROD_W'(K_CB_TO_G) * PROD_W'(r_cb1);
            r_pgr2  <= PROD_W'(K_CR_TO_G) * PROD_W'(r_cr1);
            r_pb2   <= PROD_W'(K_CB_TO_B) * PROD_W'(r_cb1);
            r_side2 <= r_side1;
        end
    end

    assign o_valid     = r_v2;
    assign o_luma      = r_y2;
    assign o_prod_r    = r_pr2;
    assign o_prod_g_cb = r_pgb2;
    assign o_prod_g_cr = r_pgr2;
    assign o_prod_b    = r_pb2;
    assign o_side      = r_side2;

endmodule

FILE: hw/rtl/ycc565_conv.sv
// Back half of the pixel pipeline: green sum and rounding stage, then the
// luma add, clamp and RGB565 pack into the output register. Depends on ycc565_pkg.
module ycc565_conv (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic [7:0]                             i_luma,
    input  logic signed [ycc565_pkg::PROD_W-1:0]   i_prod_r,
    input  logic signed [ycc565_pkg::PROD_W-1:0]   i_prod_g_cb,
    input  logic signed [ycc565_pkg::PROD_W-1:0]   i_prod_g_cr,
    input  logic signed [ycc565_pkg::PROD_W-1:0]   i_prod_b,
    input  ycc565_pkg::t_side                      i_side,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic [15:0]                            o_pixel_565,
    output ycc565_pkg::t_side                      o_side
);
    import ycc565_pkg::*;

    // Stage 3 registers: rounded offsets
    logic                    r_v3;
    logic [7:0]              r_y3;
    logic signed [OFF_W-1:0] r_off_r3;
    logic signed [OFF_W-1:0] r_off_g3;
    logic signed [OFF_W-1:0] r_off_b3;
    t_side                   r_side3;

    // Stage 4: output register
    logic        r_v4;
    logic [15:0] r_pix4;
    t_side       r_side4;

    logic                     en3;
    logic                     en4;
    logic signed [PROD_W-1:0] n_sum_g;
    logic [7:0]               n_r;
    logic [7:0]               n_g;
    logic [7:0]               n_b;

    assign en4     = !r_v4 || i_ready;
    assign en3     = !r_v3 || en4;
    assign o_ready = en3;

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en3) begin
                r_v3 <= i_valid;
            end
            if (en4) begin
                r_v4 <= r_v3;
            end
        end
    end

    // Green offset is the negated sum of both chroma terms
    assign n_sum_g = -i_prod_g_cb - i_prod_g_cr;

    // Stage 3: round each offset
    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_y3     <= i_luma;
            r_off_r3 <= round_fix16(i_prod_r);
            r_off_g3 <= round_fix16(n_sum_g);
            r_off_b3 <= round_fix16(i_prod_b);
            r_side3  <= i_side;
        end
    end

    // Add luma and clamp each color
    always_comb begin
        n_r = add_clamp(r_y3, r_off_r3);
        n_g = add_clamp(r_y3, r_off_g3);
        n_b = add_clamp(r_y3, r_off_b3);
    end

    // Stage 4: pack 5-6-5
    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_pix4  <= {n_r[7:3], n_g[7:2], n_b[7:3]};
            r_side4 <= r_side3;
        end
    end

    assign o_valid     = r_v4;
    assign o_pixel_565 = r_pix4;
    assign o_side      = r_side4;

endmodule

FILE: dv/ycbcr_to_rgb565_pixel_tb.sv
// Self-checking testbench for ycbcr_to_rgb565_pixel: drives random and edge-case pixels,
// predicts each RGB565 word and its row/frame markers, and checks every output item in order.
// Depends only on the ycbcr_to_rgb565_pixel top level and what it pulls in.
module ycbcr_to_rgb565_pixel_tb;

    // Color matrix in 16.16 fixed point, and chroma offset
    localparam int COEF_CR_R   = 'h166e9;
    localparam int COEF_CB_G   = 'h0581a;
    localparam int COEF_CR_G   = 'h0b6d2;
    localparam int COEF_CB_B   = 'h1c5a2;
    localparam int CHROMA_MID  = 128;
    localparam int HALF_LSB    = 32768;

    localparam int NUM_RANDOM_PIXELS = 1600;
    localparam int STALL_LIMIT       = 500;
    localparam int LONG_HOLD_CYCLES  = 60;
    localparam int DRAIN_CYCLES      = 8;

    // One converted pixel with its markers
    typedef struct packed {
        logic [15:0] pixel_565;
        logic        row_end;
        logic        frame_end;
    } t_rgb565_item;

    // Predicts the converted pixels and matches them against the output stream
    class rgb565_scoreboard;
        t_rgb565_item pending_pixels[$];
        int           fail_count;

        function new();
            fail_count = 0;
        endfunction

        // Add offset to luma, clamp to one byte
        function logic [7:0] clamp_channel(input int luma, input int offset);
            int s;
            s = luma + offset;
            if (s < 0) begin
                return 8'd0;
            end else if (s > 255) begin
                return 8'd255;
            end
            return s[7:0];
        endfunction

        // Fixed-point conversion with round-half-up, then pack to 565
        function logic [15:0] convert_pixel(input logic [7:0] y, input logic [7:0] cb_raw,
                                            input logic [7:0] cr_raw);
            int         cb;
            int         cr;
            int         r_off;
            int         g_off;
            int         b_off;
            logic [7:0] r;
            logic [7:0] g;
            logic [7:0] b;
            cb    = int'(cb_raw) - CHROMA_MID;
            cr    = int'(cr_raw) - CHROMA_MID;
            r_off = (COEF_CR_R * cr + HALF_LSB) >>> 16;
            g_off = (-COEF_CB_G * cb - COEF_CR_G * cr + HALF_LSB) >>> 16;
            b_off = (COEF_CB_B * cb + HALF_LSB) >>> 16;
            r     = clamp_channel(int'(y), r_off);
            g     = clamp_channel(int'(y), g_off);
            b     = clamp_channel(int'(y), b_off);
            return {r[7:3], g[7:2], b[7:3]};
        endfunction

        // Accepted input item: queue its expected result
        function void note_pixel(input logic [23:0] tdata, input logic [1:0] tuser);
            t_rgb565_item exp_item;
            exp_item.pixel_565 = convert_pixel(tdata[7:0], tdata[15:8], tdata[23:16]);
            exp_item.row_end   = tuser[0];
            exp_item.frame_end = tuser[1];
            pending_pixels.push_back(exp_item);
        endfunction

        // Accepted output item: compare with the oldest expectation
        function void check_pixel(input logic [15:0] tdata, input logic [1:0] tuser);
            t_rgb565_item exp_item;
            if (pending_pixels.size() == 0) begin
                $error("unexpected output item: pixel_565=%h tuser=%b", tdata, tuser);
                fail_count++;
                return;
            end
            exp_item = pending_pixels.pop_front();
            if (tdata !== exp_item.pixel_565) begin
                $error("pixel_565 mismatch: expected %h, got %h", exp_item.pixel_565, tdata);
                fail_count++;
            end
            if (tuser[0] !== exp_item.row_end) begin
                $error("row_end_out mismatch: expected %b, got %b", exp_item.row_end, tuser[0]);
                fail_count++;
            end
            if (tuser[1] !== exp_item.frame_end) begin
                $error("frame_end_out mismatch: expected %b, got %b",
                       exp_item.frame_end, tuser[1]);
                fail_count++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;  // [7:0] luma, [15:8] chroma_blue, [23:16] chroma_red
    logic [1:0]  s_axis_tuser = '0;  // [0] row_end, [1] frame_end
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;       // [15:0] pixel_565
    logic [1:0]  m_axis_tuser;       // [0] row_end_out, [1] frame_end_out

    rgb565_scoreboard sb = new();

    bit no_idle = 1'b0;        // burst stretch: neither side inserts gaps
    bit hold_request = 1'b0;   // ask the receiver for one long stall
    bit hold_issued = 1'b0;    // the long stall has been asked for
    int idle_cycles = 0;

    ycbcr_to_rgb565_pixel u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Input and output monitors, sampled at the edge
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            sb.note_pixel(s_axis_tdata, s_axis_tuser);
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_pixel(m_axis_tdata, m_axis_tuser);
        end
    end

    // Watchdog: too long with no item moving on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles = idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Receiver: random stall per item, plus one long hold on request
    initial begin
        int stall;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_request) begin
                stall = LONG_HOLD_CYCLES;
                hold_request = 1'b0;
            end else begin
                stall = no_idle ? 0 : $urandom_range(0, 3);
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    // Offer one pixel after a random gap and wait until it is taken
    task automatic send_pixel(input logic [7:0] y, input logic [7:0] cb, input logic [7:0] cr,
                              input logic row_end, input logic frame_end);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {cr, cb, y};
        s_axis_tuser  <= {frame_end, row_end};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Byte leaning toward the extremes now and then
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Main sequence
    initial begin
        int sent;
        int rows;
        int cols;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: field extremes, clamping both ways, markers
        send_pixel(8'd0,   8'd0,   8'd0,   1'b0, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b0, 1'b0);
        send_pixel(8'd0,   8'd128, 8'd128, 1'b0, 1'b0);
        send_pixel(8'd255, 8'd128, 8'd128, 1'b0, 1'b0);
        send_pixel(8'd128, 8'd128, 8'd128, 1'b1, 1'b0);
        send_pixel(8'd0,   8'd128, 8'd0,   1'b0, 1'b1);  // red below zero
        send_pixel(8'd255, 8'd128, 8'd255, 1'b1, 1'b1);  // red above 255
        send_pixel(8'd0,   8'd0,   8'd128, 1'b0, 1'b0);  // blue below zero
        send_pixel(8'd255, 8'd255, 8'd128, 1'b0, 1'b0);  // blue above 255
        send_pixel(8'd0,   8'd255, 8'd255, 1'b0, 1'b0);  // green below zero
        send_pixel(8'd255, 8'd0,   8'd0,   1'b0, 1'b0);  // green above 255
        send_pixel(8'd16,  8'd128, 8'd128, 1'b1, 1'b0);
        send_pixel(8'd235, 8'd240, 8'd16,  1'b0, 1'b0);
        send_pixel(8'd81,  8'd90,  8'd240, 1'b0, 1'b0);
        send_pixel(8'd145, 8'd54,  8'd34,  1'b1, 1'b0);
        send_pixel(8'd41,  8'd240, 8'd110, 1'b1, 1'b1);

        // Random frames, some in bursts, with stray items between them
        sent = 0;
        while (sent < NUM_RANDOM_PIXELS) begin
            no_idle = ($urandom_range(0, 3) == 0);
            if (sent > 200 && !hold_issued) begin
                hold_request = 1'b1;
                hold_issued  = 1'b1;
            end
            if ($urandom_range(0, 7) == 0) begin
                repeat ($urandom_range(1, 4)) begin
                    send_pixel(pick_byte(), pick_byte(), pick_byte(),
                               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                    sent++;
                end
            end else begin
                rows = $urandom_range(1, 4);
                cols = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 10);
                for (int r = 0; r < rows; r++) begin
                    for (int c = 0; c < cols; c++) begin
                        send_pixel(pick_byte(), pick_byte(), pick_byte(),
                                   c == cols - 1, (c == cols - 1) && (r == rows - 1));
                        sent++;
                    end
                end
            end
        end
        s_axis_tvalid <= 1'b0;
        no_idle = 1'b0;

        // Drain: the watchdog bounds this wait
        while (sb.pending_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.fail_count == 0 && sb.pending_pixels.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
